@@ src/sacl_pkg.sv @@
// ----------------------------------------------------------------------------
// sacl_pkg
// shared constants and types for the set associative cache with lru/lfu
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int WAYS_DEF           = 8;
   localparam int MAX_INDEX_BITS_DEF = 8;
   localparam int ADDR_BITS_DEF      = 64;
   localparam int STAMP_BITS_DEF     = 32;
   localparam int CNT_BITS           = 32;
   localparam int MAX_OFFSET         = 16;

   localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
   localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
   localparam logic [1:0] REG_WAYS        = 2'd2;
   localparam logic [1:0] REG_USE_LFU     = 2'd3;

   localparam logic [1:0] ST_HIT   = 2'd0;
   localparam logic [1:0] ST_FILL  = 2'd1;
   localparam logic [1:0] ST_EVICT = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_READ,
      PH_SCAN,
      PH_DONE
   } phase_type;

endpackage

@@ src/sacl_if.sv @@
// ----------------------------------------------------------------------------
// sacl_if
// valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
interface sacl_if #(
   parameter int WIDTH = 64
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ src/set_assoc_cache_lru_lfu.sv @@
// flow: once a request is accepted, the ways in use of its set are scanned, one way of the
//   set read a cycle, then the chosen way and the set clock are written back and the response
//   registered; no new request is accepted until the response has been taken
// reset: clearing pass over the line memory and the set clock memory,
//   during which no request is accepted
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_lfu
// set associative cache lookup with lru or lfu replacement and running totals
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_lfu #(
   parameter int WAYS           = sacl_pkg::WAYS_DEF,
   parameter int MAX_INDEX_BITS = sacl_pkg::MAX_INDEX_BITS_DEF,
   parameter int ADDR_BITS      = sacl_pkg::ADDR_BITS_DEF,
   parameter int STAMP_BITS     = sacl_pkg::STAMP_BITS_DEF
) (
   input  logic  clock,
   input  logic  reset,
   sacl_if.sink   req,
   sacl_if.source rsp,
   sacl_if.sink   csr
);
   localparam int CB     = sacl_pkg::CNT_BITS;
   localparam int SETS   = 1 << MAX_INDEX_BITS;
   localparam int SB     = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
   localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LDEP   = SETS * WAYS;
   localparam int LAB    = $clog2(LDEP) > 0 ? $clog2(LDEP) : 1;
   localparam int SDEP   = (SETS > 1) ? SETS : 2;
   localparam int SAB    = $clog2(SDEP);
   // line word: valid, block, stamp, uses
   localparam int LW     = 1 + ADDR_BITS + STAMP_BITS + CB;
   localparam int WCB    = $clog2(WAYS + 1);
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
   localparam logic [CB-1:0]         CNT_MAX   = '1;

   // response payload: status, victim, insert, hits, misses, evictions
   // (victim/insert carried at 64 bits, address zero-extended)

   // configuration registers
   logic [4:0] offset_bits_ff, offset_bits_in;
   logic [3:0] index_bits_ff, index_bits_in;
   logic [3:0] ways_ff, ways_in;
   logic       lfu_ff, lfu_in;

   assign csr.ready = 1'b1;

   always_comb begin
      offset_bits_in = offset_bits_ff;
      index_bits_in  = index_bits_ff;
      ways_in        = ways_ff;
      lfu_in         = lfu_ff;
      if (csr.valid && csr.data[127:66] == '0) begin
         case (csr.data[65:64])
            sacl_pkg::REG_OFFSET_BITS: offset_bits_in = csr.data[4:0];
            sacl_pkg::REG_INDEX_BITS:  index_bits_in  = csr.data[3:0];
            sacl_pkg::REG_WAYS:        ways_in        = csr.data[3:0];
            sacl_pkg::REG_USE_LFU:     lfu_in         = csr.data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= 5'd4;
         index_bits_ff  <= 4'd4;
         ways_ff        <= 4'd1;
         lfu_ff         <= 1'b0;
      end else begin
         offset_bits_ff <= offset_bits_in;
         index_bits_ff  <= index_bits_in;
         ways_ff        <= ways_in;
         lfu_ff         <= lfu_in;
      end
   end

   // effective geometry
   logic [4:0]     ob;
   logic [3:0]     ib;
   logic [WCB-1:0] nw;
   always_comb begin
      ob = (offset_bits_ff > 5'(sacl_pkg::MAX_OFFSET)) ? 5'(sacl_pkg::MAX_OFFSET)
                                                        : offset_bits_ff;
      ib = (index_bits_ff > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_bits_ff;
      if (ways_ff == 4'd0) nw = WCB'(1);
      else if (32'(ways_ff) > WAYS) nw = WCB'(WAYS);
      else nw = WCB'(ways_ff);
   end

   // state
   sacl_pkg::phase_type ph_ff, ph_in;
   logic              clr_ff, clr_in;
   logic [LAB-1:0]    clr_cnt_ff, clr_cnt_in;
   logic [WB:0]       way_ff, way_in;      // way being read
   logic [WB:0]       scan_ff, scan_in;    // way whose data is in rdata
   logic [ADDR_BITS-1:0] block_ff, block_in;
   logic [SB-1:0]     set_ff, set_in;
   logic [STAMP_BITS-1:0] clk_ff, clk_in;
   logic              found_ff, found_in, empty_ff, empty_in;
   logic [WB-1:0]     fway_ff, fway_in, eway_ff, eway_in, pick_ff, pick_in;
   logic [STAMP_BITS-1:0] pstamp_ff, pstamp_in;
   logic [CB-1:0]     puses_ff, puses_in, fuses_ff, fuses_in;
   logic [ADDR_BITS-1:0] pblock_ff, pblock_in;
   logic [CB-1:0]     hits_ff, hits_in, miss_ff, miss_in, evic_ff, evic_in;
   logic              rv_ff, rv_in;
   logic [1:0]        rst_ff, rst_in;
   logic [63:0]       rvic_ff, rvic_in, rins_ff, rins_in;

   // memories
   logic            l_we, s_we;
   logic [LAB-1:0]  l_addr;
   logic [SAB-1:0]  s_addr;
   logic [LW-1:0]   l_wdata, l_rdata;
   logic [STAMP_BITS-1:0] s_wdata, s_rdata;

   sacl_ram #(.WIDTH(LW), .DEPTH(LDEP)) u_lines (
      .clock(clock), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
   sacl_ram #(.WIDTH(STAMP_BITS), .DEPTH(SDEP)) u_clocks (
      .clock(clock), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

   logic                  r_valid;
   logic [ADDR_BITS-1:0]  r_block;
   logic [STAMP_BITS-1:0] r_stamp;
   logic [CB-1:0]         r_uses;
   assign {r_valid, r_block, r_stamp, r_uses} = l_rdata;

   logic [ADDR_BITS-1:0] a_addr, a_mask, a_block;
   logic [ADDR_BITS-1:0] a_set_full;
   logic [SB-1:0]        a_set;

   assign req.ready = (ph_ff == sacl_pkg::PH_IDLE) && !clr_ff && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.data  = {rst_ff, rvic_ff, rins_ff, hits_ff, miss_ff, evic_ff};

   always_comb begin
      logic better;
      logic [LAB-1:0] wsel;
      a_addr     = req.data[ADDR_BITS-1:0];
      a_mask     = ~((ADDR_BITS'(1) << ob) - ADDR_BITS'(1));
      a_block    = a_addr & a_mask;
      a_set_full = (a_block >> ob) & ((ADDR_BITS'(1) << ib) - ADDR_BITS'(1));
      a_set      = SB'(a_set_full);
      ph_in = ph_ff; clr_in = clr_ff; clr_cnt_in = clr_cnt_ff;
      way_in = way_ff; scan_in = scan_ff; block_in = block_ff; set_in = set_ff;
      clk_in = clk_ff; found_in = found_ff; empty_in = empty_ff;
      fway_in = fway_ff; eway_in = eway_ff; pick_in = pick_ff;
      pstamp_in = pstamp_ff; puses_in = puses_ff; pblock_in = pblock_ff;
      fuses_in = fuses_ff;
      hits_in = hits_ff; miss_in = miss_ff; evic_in = evic_ff;
      rv_in = rv_ff; rst_in = rst_ff; rvic_in = rvic_ff; rins_in = rins_ff;
      l_we = 1'b0; s_we = 1'b0; l_wdata = '0; s_wdata = '0;
      l_addr = LAB'(({{(32-SB){1'b0}}, set_ff} * WAYS) + 32'(way_ff[WB-1:0]));
      s_addr = SAB'(set_ff);
      better = 1'b0;
      wsel = '0;
      if (rsp.valid && rsp.ready) rv_in = 1'b0;
      if (clr_ff) begin
         l_we = 1'b1; s_we = 1'b1;
         s_addr = SAB'(clr_cnt_ff);
         l_addr = clr_cnt_ff;
         clr_cnt_in = clr_cnt_ff + LAB'(1);
         if (32'(clr_cnt_ff) == LDEP - 1) clr_in = 1'b0;
         if (32'(clr_cnt_ff) >= SDEP) s_we = 1'b0;
      end else begin
         case (ph_ff)
            sacl_pkg::PH_IDLE: begin
               if (req.valid && req.ready) begin
                  block_in = a_block; set_in = a_set;
                  s_addr = SAB'(a_set);
                  l_addr = LAB'({{(32-SB){1'b0}}, a_set} * WAYS);
                  way_in = (WB+1)'(1); scan_in = '0;
                  found_in = 1'b0; empty_in = 1'b0; pick_in = '0;
                  ph_in = sacl_pkg::PH_SCAN;
               end
            end
            sacl_pkg::PH_SCAN: begin
               // rdata holds way scan_ff; way_ff is being read
               if (scan_ff == '0)
                  clk_in = (s_rdata == STAMP_MAX) ? s_rdata : s_rdata + 1'b1;
               if (r_valid && r_block == block_ff && !found_ff) begin
                  found_in = 1'b1; fway_in = scan_ff[WB-1:0]; fuses_in = r_uses;
               end
               if (!r_valid && !empty_ff) begin
                  empty_in = 1'b1; eway_in = scan_ff[WB-1:0];
               end
               if (scan_ff == '0) better = 1'b1;
               else if (lfu_ff)
                  better = (r_uses < puses_ff) ||
                           (r_uses == puses_ff && r_stamp < pstamp_ff);
               else better = r_stamp < pstamp_ff;
               if (better) begin
                  pick_in = scan_ff[WB-1:0]; pstamp_in = r_stamp;
                  puses_in = r_uses; pblock_in = r_block;
               end
               scan_in = scan_ff + 1'b1;
               way_in  = way_ff + 1'b1;
               if (WCB'(scan_ff) + WCB'(1) >= nw) ph_in = sacl_pkg::PH_DONE;
            end
            sacl_pkg::PH_DONE: begin
               l_we = 1'b1; s_we = 1'b1; s_wdata = clk_ff;
               if (found_ff) begin
                  wsel = LAB'(fway_ff);
                  l_wdata = {1'b1, block_ff, clk_ff,
                             (fuses_ff == CNT_MAX) ? fuses_ff : fuses_ff + 1'b1};
                  hits_in = (hits_ff == CNT_MAX) ? hits_ff : hits_ff + 1'b1;
                  rst_in = sacl_pkg::ST_HIT; rvic_in = '0; rins_in = '0;
               end else begin
                  wsel = empty_ff ? LAB'(eway_ff) : LAB'(pick_ff);
                  l_wdata = {1'b1, block_ff, clk_ff, {CB{1'b0}}};
                  miss_in = (miss_ff == CNT_MAX) ? miss_ff : miss_ff + 1'b1;
                  rins_in = 64'(block_ff);
                  if (empty_ff) begin
                     rst_in = sacl_pkg::ST_FILL; rvic_in = '0;
                  end else begin
                     rst_in = sacl_pkg::ST_EVICT; rvic_in = 64'(pblock_ff);
                     evic_in = (evic_ff == CNT_MAX) ? evic_ff : evic_ff + 1'b1;
                  end
               end
               l_addr = LAB'(({{(32-SB){1'b0}}, set_ff} * WAYS) + 32'(wsel));
               rv_in = 1'b1;
               ph_in = sacl_pkg::PH_IDLE;
            end
            default: ph_in = sacl_pkg::PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= sacl_pkg::PH_IDLE;
         clr_ff <= 1'b1; clr_cnt_ff <= '0;
         hits_ff <= '0; miss_ff <= '0; evic_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in; clr_ff <= clr_in; clr_cnt_ff <= clr_cnt_in;
         hits_ff <= hits_in; miss_ff <= miss_in; evic_ff <= evic_in;
         rv_ff <= rv_in;
      end
      way_ff <= way_in; scan_ff <= scan_in; block_ff <= block_in; set_ff <= set_in;
      clk_ff <= clk_in; found_ff <= found_in; empty_ff <= empty_in;
      fway_ff <= fway_in; eway_ff <= eway_in; pick_ff <= pick_in;
      pstamp_ff <= pstamp_in; puses_ff <= puses_in; pblock_ff <= pblock_in;
      fuses_ff <= fuses_in;
      rst_ff <= rst_in; rvic_ff <= rvic_in; rins_ff <= rins_in;
   end

`ifndef ASSERT_OFF
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req.ready) else $error("request taken during clear");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      ph_ff == sacl_pkg::PH_DONE |=> rsp.valid) else $error("no response");
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rst_ff != 2'd3) else $error("bad status");
`endif
endmodule

@@ src/sacl_ram.sv @@
// ----------------------------------------------------------------------------
// sacl_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;
endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the set associative cache against a behavioral cache kept in the
// bench. Each request is predicted when the block accepts it, and every
// response is compared field by field in order. The run steps through
// several geometries and both replacement policies. Both channels idle at
// random, and the response side is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;

   localparam int NSETS    = 256;
   localparam int NWAYS    = 8;
   localparam int RSP_W    = 2 + 64 + 64 + 3 * 32;
   localparam int CSR_W    = 128;
   localparam int WD_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] victim;
      logic [63:0] insert;
      logic [31:0] hits;
      logic [31:0] misses;
      logic [31:0] evicts;
   } lookup_type;

   logic clock;
   logic reset;

   sacl_if #(.WIDTH(64))    req_if ();
   sacl_if #(.WIDTH(RSP_W)) rsp_if ();
   sacl_if #(.WIDTH(CSR_W)) csr_if ();

   set_assoc_cache_lru_lfu u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // bench copy of the cache contents and settings
   logic [4:0]  cfg_offset;
   logic [3:0]  cfg_index;
   logic [3:0]  cfg_ways;
   logic        cfg_lfu;
   logic        way_valid [NSETS*NWAYS];
   logic [63:0] way_block [NSETS*NWAYS];
   logic [31:0] way_stamp [NSETS*NWAYS];
   logic [31:0] way_uses  [NSETS*NWAYS];
   logic [31:0] set_time  [NSETS];
   logic [31:0] hit_sum, miss_sum, evict_sum;

   logic [63:0] pending_addr [$];
   lookup_type  expected_lookups [$];
   int          errors;
   int          quiet_cycles;
   logic        gaps_on;
   logic        long_hold;

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // one cache access in the bench model
   function automatic lookup_type access_cache(logic [63:0] addr);
      lookup_type r;
      int ob, ib, nw, base, hit_way, free_way, pick, a, b;
      logic [63:0] blk;
      logic [31:0] now;
      logic older;
      ob = (cfg_offset > 16) ? 16 : cfg_offset;
      ib = (cfg_index > 8) ? 8 : cfg_index;
      nw = (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : cfg_ways);
      blk = addr & ~((64'd1 << ob) - 64'd1);
      base = int'((blk >> ob) & ((64'd1 << ib) - 64'd1));
      if (set_time[base] != 32'hFFFF_FFFF) set_time[base] = set_time[base] + 32'd1;
      now = set_time[base];
      base = base * NWAYS;
      hit_way = -1;
      free_way = -1;
      r = '0;
      for (int w = 0; w < nw; w++) begin
         if (way_valid[base+w] && way_block[base+w] == blk && hit_way < 0) hit_way = w;
         if (!way_valid[base+w] && free_way < 0) free_way = w;
      end
      if (hit_way >= 0) begin
         way_stamp[base+hit_way] = now;
         way_uses[base+hit_way] = sat_inc(way_uses[base+hit_way]);
         hit_sum = sat_inc(hit_sum);
         r.status = sacl_pkg::ST_HIT;
      end else begin
         if (free_way >= 0) begin
            pick = free_way;
            way_valid[base+pick] = 1'b1;
            r.status = sacl_pkg::ST_FILL;
         end else begin
            // victim choice: oldest stamp, or fewest uses then oldest
            pick = 0;
            for (int w = 1; w < nw; w++) begin
               a = base + w;
               b = base + pick;
               older = way_stamp[a] < way_stamp[b];
               if (cfg_lfu) begin
                  if (way_uses[a] < way_uses[b] || (way_uses[a] == way_uses[b] && older))
                     pick = w;
               end else if (older) begin
                  pick = w;
               end
            end
            r.victim = way_block[base+pick];
            evict_sum = sat_inc(evict_sum);
            r.status = sacl_pkg::ST_EVICT;
         end
         way_block[base+pick] = blk;
         way_stamp[base+pick] = now;
         way_uses[base+pick] = 32'd0;
         r.insert = blk;
         miss_sum = sat_inc(miss_sum);
      end
      r.hits = hit_sum;
      r.misses = miss_sum;
      r.evicts = evict_sum;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // request driver: predicts at acceptance, then waits a drawn gap
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
         req_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_lookups.push_back(access_cache(req_if.data));
            req_gap = gaps_on ? $urandom_range(0, 6) : 0;
         end
         if (req_if.valid && !req_if.ready) begin
            // keep offering the same request
         end else if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
         end else if (pending_addr.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.data <= pending_addr.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response side: random stalls, plus one long hold-off when asked
   int rsp_stall;
   int hold_left;
   lookup_type got, want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall = 0;
         hold_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_if.data;
            if (expected_lookups.size() == 0) begin
               $error("response with nothing expected: %h", got);
               errors++;
            end else begin
               want = expected_lookups.pop_front();
               if (got.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status); errors++;
               end
               if (got.victim !== want.victim) begin
                  $error("evicted block exp %h got %h", want.victim, got.victim); errors++;
               end
               if (got.insert !== want.insert) begin
                  $error("inserted block exp %h got %h", want.insert, got.insert); errors++;
               end
               if (got.hits !== want.hits) begin
                  $error("hits_total exp %0d got %0d", want.hits, got.hits); errors++;
               end
               if (got.misses !== want.misses) begin
                  $error("misses_total exp %0d got %0d", want.misses, got.misses); errors++;
               end
               if (got.evicts !== want.evicts) begin
                  $error("evictions_total exp %0d got %0d", want.evicts, got.evicts);
                  errors++;
               end
            end
            rsp_stall = gaps_on ? $urandom_range(0, 6) : 0;
         end
         if (long_hold && hold_left == 0) hold_left = 400;
         if (hold_left > 1) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [4:0] val);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.data <= {64'(idx), 64'(val)};
      forever begin
         @(posedge clock);
         if (csr_if.ready) break;
      end
      csr_if.valid <= 1'b0;
      case (idx)
         sacl_pkg::REG_OFFSET_BITS: cfg_offset = val;
         sacl_pkg::REG_INDEX_BITS:  cfg_index = val[3:0];
         sacl_pkg::REG_WAYS:        cfg_ways = val[3:0];
         sacl_pkg::REG_USE_LFU:     cfg_lfu = val[0];
         default: ;
      endcase
   endtask

   // sender pause: wait until every expected response is back
   task automatic drain();
      do @(negedge clock);
      while (pending_addr.size() != 0 || req_if.valid || expected_lookups.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   // random accesses drawn mostly from a small pool of blocks so lines hit
   task automatic random_accesses(int count);
      logic [63:0] pool [];
      logic [63:0] a;
      int ob;
      ob = (cfg_offset > 16) ? 16 : cfg_offset;
      pool = new[$urandom_range(3, 24)];
      foreach (pool[i]) pool[i] = {$urandom, $urandom};
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0) begin
            a = {$urandom, $urandom};
         end else begin
            a = pool[$urandom_range(0, pool.size() - 1)];
            a = (a & ~((64'd1 << ob) - 64'd1)) | ({$urandom, $urandom} & ((64'd1 << ob) - 1));
         end
         pending_addr.push_back(a);
      end
   endtask

   // settings per phase: offset, index, ways, policy
   logic [4:0] ph_cfg [8][4] = '{
      '{5'd4,  5'd2,  5'd4,  5'd0},
      '{5'd4,  5'd2,  5'd4,  5'd1},
      '{5'd0,  5'd0,  5'd8,  5'd0},
      '{5'd16, 5'd8,  5'd8,  5'd1},
      '{5'd31, 5'd15, 5'd15, 5'd0},
      '{5'd6,  5'd3,  5'd0,  5'd1},
      '{5'd2,  5'd1,  5'd2,  5'd1},
      '{5'd5,  5'd4,  5'd8,  5'd0}
   };

   initial begin
      errors = 0;
      gaps_on = 1'b1;
      long_hold = 1'b0;
      cfg_offset = 5'd4;
      cfg_index = 4'd4;
      cfg_ways = 4'd1;
      cfg_lfu = 1'b0;
      hit_sum = '0;
      miss_sum = '0;
      evict_sum = '0;
      for (int i = 0; i < NSETS * NWAYS; i++) begin
         way_valid[i] = 1'b0;
         way_block[i] = '0;
         way_stamp[i] = '0;
         way_uses[i] = '0;
      end
      for (int i = 0; i < NSETS; i++) set_time[i] = '0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset geometry, one way per set, extremes of the address
      pending_addr.push_back(64'h0);
      pending_addr.push_back(64'h0);                   // hit
      pending_addr.push_back(64'h0000_0000_0000_000F); // same block, offset bits set
      pending_addr.push_back(64'hFFFF_FFFF_FFFF_FFFF);
      pending_addr.push_back(64'hFFFF_FFFF_FFFF_FFF0); // hit on all ones block
      pending_addr.push_back(64'h8000_0000_0000_0000); // same set as zero, evicts it
      pending_addr.push_back(64'h0);                   // evicts back
      pending_addr.push_back(64'h0000_0000_0000_0010); // next set
      pending_addr.push_back(64'h0000_0000_0000_0100); // set 0 again, other tag
      pending_addr.push_back(64'h5555_5555_5555_5555);
      pending_addr.push_back(64'hAAAA_AAAA_AAAA_AAAA);
      pending_addr.push_back(64'h5555_5555_5555_5550);
      drain();

      // lfu with two ways: the used line survives, the unused one goes
      write_reg(sacl_pkg::REG_WAYS, 5'd2);
      write_reg(sacl_pkg::REG_USE_LFU, 5'd1);
      pending_addr.push_back(64'h1000);
      pending_addr.push_back(64'h2000);
      pending_addr.push_back(64'h1000);
      pending_addr.push_back(64'h1000);
      pending_addr.push_back(64'h3000);
      pending_addr.push_back(64'h2000);
      pending_addr.push_back(64'h1000);
      drain();

      for (int p = 0; p < 8; p++) begin
         write_reg(sacl_pkg::REG_OFFSET_BITS, ph_cfg[p][0]);
         write_reg(sacl_pkg::REG_INDEX_BITS, ph_cfg[p][1]);
         write_reg(sacl_pkg::REG_WAYS, ph_cfg[p][2]);
         write_reg(sacl_pkg::REG_USE_LFU, ph_cfg[p][3]);
         gaps_on = (p % 3) != 2;
         long_hold = (p == 3);
         random_accesses(90);
         drain();
         long_hold = 1'b0;
      end

      drain();
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
